// ===== sv/tcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console: command kinds, the queue
// word passed from the front end to the executor, and character codes.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Widest coordinates the parameter ranges allow
    localparam int ROW_MAX_W = 6;
    localparam int COL_MAX_W = 7;

    localparam int CELL_W  = 16;
    localparam int BYTE_W  = 8;

    localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'h0A;
    localparam logic [BYTE_W-1:0] SPACE_BYTE   = 8'h20;
    localparam logic [BYTE_W-1:0] RESET_COLOR  = 8'h07;

    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_READ,
        CMD_READ_OOB
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind              kind;
        logic [BYTE_W-1:0]      char_byte;
        logic [ROW_MAX_W-1:0]   row;
        logic [COL_MAX_W-1:0]   col;
    } t_item;

endpackage

// ===== sv/tcc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_front
// Command front end: takes a word when the queue has room and the screen is
// not being cleared, and sorts it into put, newline, read or off-screen read.
// ----------------------------------------------------------------------------
module tcc_front
    import tcc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int ROW_W  = $clog2(ROWS),
    localparam int COL_W  = $clog2(COLUMNS)
) (
    input  logic                start,
    input  logic                i_q_full,
    input  logic                i_clearing,
    input  logic                i_operation,
    input  logic [BYTE_W-1:0]   i_character,
    input  logic [ROW_W-1:0]    i_read_row,
    input  logic [COL_W-1:0]    i_read_col,
    output logic                o_busy,
    output logic                o_push,
    output t_item               o_item
);

    logic in_range;

    assign o_busy   = i_q_full | i_clearing;
    assign o_push   = start & ~o_busy;

    assign in_range = ({1'b0, i_read_row} < (ROW_W + 1)'(ROWS)) &&
                      ({1'b0, i_read_col} < (COL_W + 1)'(COLUMNS));

    always_comb begin
        o_item.char_byte = i_character;
        o_item.row       = ROW_MAX_W'(i_read_row);
        o_item.col       = COL_MAX_W'(i_read_col);
        if (i_operation == OP_READ) begin
            o_item.kind = in_range ? CMD_READ : CMD_READ_OOB;
        end else if (i_character == NEWLINE_BYTE) begin
            o_item.kind = CMD_NEWLINE;
        end else begin
            o_item.kind = CMD_PUT;
        end
    end

endmodule

// ===== sv/tcc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_queue
// Two-entry in-order queue between the front end and the executor.
// ----------------------------------------------------------------------------
module tcc_queue
    import tcc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output logic    o_valid,
    output logic    o_full,
    output t_item   o_item
);

    t_item              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wptr;
    logic [QPTR_W-1:0]  r_rptr;
    logic [QPTR_W:0]    r_count;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign o_item  = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue popped while empty");
`endif

endmodule

// ===== sv/tcc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_back
// Executor: owns the screen store, cursor and scroll offset. Rows are kept
// in a ring; a scroll moves the top-row pointer and blanks the old top row.
// ----------------------------------------------------------------------------
module tcc_back
    import tcc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int ROW_W  = $clog2(ROWS),
    localparam int COL_W  = $clog2(COLUMNS),
    localparam int CELLS  = ROWS * COLUMNS,
    localparam int ADDR_W = $clog2(CELLS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [BYTE_W-1:0]   i_cfg_data,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_q_pop,
    output logic                o_clearing,
    output logic                o_strobe,
    output logic [CELL_W-1:0]   o_cell_entry,
    output logic [ROW_W-1:0]    o_cursor_row,
    output logic [COL_W-1:0]    o_cursor_col
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RDATA,
        S_FILL
    } t_state;

    t_state             r_state,    n_state;
    logic [ADDR_W-1:0]  r_clr_addr, n_clr_addr;
    logic [ROW_W-1:0]   r_top,      n_top;
    logic [ROW_W-1:0]   r_row,      n_row;
    logic [COL_W-1:0]   r_col,      n_col;
    t_item              r_item,     n_item;
    logic [ROW_W-1:0]   r_prow,     n_prow;
    logic [ROW_W-1:0]   r_fill_row, n_fill_row;
    logic [COL_W-1:0]   r_fill_col, n_fill_col;
    logic [BYTE_W-1:0]  r_color;
    logic               r_strobe,   n_strobe;
    logic [CELL_W-1:0]  r_out_cell, n_out_cell;

    logic [CELL_W-1:0]  mem [CELLS];
    logic [CELL_W-1:0]  r_mem_rdata;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [CELL_W-1:0]  mem_wdata;

    logic [ROW_W-1:0]   logical_row;
    logic [ROW_W:0]     prow_sum;
    logic [COL_W:0]     col_inc;
    logic [ROW_W:0]     row_inc;
    logic [COL_W-1:0]   exec_col;
    logic               wrap_line;

    assign o_q_pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_clearing   = (r_state == S_CLEAR);
    assign o_strobe     = r_strobe;
    assign o_cell_entry = r_out_cell;
    assign o_cursor_row = r_row;
    assign o_cursor_col = r_col;

    assign logical_row = (i_q_item.kind == CMD_READ) ? i_q_item.row[ROW_W-1:0] : r_row;
    assign prow_sum    = {1'b0, r_top} + {1'b0, logical_row};
    assign col_inc     = {1'b0, r_col} + 1'b1;
    assign row_inc     = {1'b0, r_row} + 1'b1;
    assign exec_col    = (r_item.kind == CMD_READ) ? r_item.col[COL_W-1:0] : r_col;

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_top      = r_top;
        n_row      = r_row;
        n_col      = r_col;
        n_item     = r_item;
        n_prow     = r_prow;
        n_fill_row = r_fill_row;
        n_fill_col = r_fill_col;
        n_strobe   = 1'b0;
        n_out_cell = r_out_cell;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = r_clr_addr;
        mem_wdata  = {RESET_COLOR, SPACE_BYTE};
        wrap_line  = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    n_item = i_q_item;
                    // map the screen row onto the ring of stored rows
                    if (prow_sum >= (ROW_W + 1)'(ROWS)) begin
                        n_prow = ROW_W'(prow_sum - (ROW_W + 1)'(ROWS));
                    end else begin
                        n_prow = prow_sum[ROW_W-1:0];
                    end
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                mem_addr   = ADDR_W'(ADDR_W'(r_prow) * ADDR_W'(COLUMNS) + ADDR_W'(exec_col));
                mem_wdata  = {r_color, r_item.char_byte};
                n_out_cell = '0;
                case (r_item.kind)
                    CMD_READ: begin
                        mem_re  = 1'b1;
                        n_state = S_RDATA;
                    end
                    CMD_READ_OOB: begin
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end
                    CMD_PUT: begin
                        mem_we = 1'b1;
                        if (col_inc < (COL_W + 1)'(COLUMNS)) begin
                            n_col    = col_inc[COL_W-1:0];
                            n_strobe = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            wrap_line = 1'b1;
                        end
                    end
                    CMD_NEWLINE: begin
                        wrap_line = 1'b1;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
                if (wrap_line) begin
                    n_col = '0;
                    if (row_inc < (ROW_W + 1)'(ROWS)) begin
                        n_row    = row_inc[ROW_W-1:0];
                        n_strobe = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        // old top row becomes the new bottom row: blank it
                        n_row      = ROW_W'(ROWS - 1);
                        n_fill_row = r_top;
                        n_fill_col = '0;
                        n_top      = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + 1'b1;
                        n_state    = S_FILL;
                    end
                end
            end
            S_RDATA: begin
                n_out_cell = r_mem_rdata;
                n_strobe   = 1'b1;
                n_state    = S_IDLE;
            end
            S_FILL: begin
                mem_we     = 1'b1;
                mem_addr   = ADDR_W'(ADDR_W'(r_fill_row) * ADDR_W'(COLUMNS) +
                                     ADDR_W'(r_fill_col));
                mem_wdata  = {r_color, SPACE_BYTE};
                n_fill_col = r_fill_col + 1'b1;
                if (r_fill_col == COL_W'(COLUMNS - 1)) begin
                    n_out_cell = '0;
                    n_strobe   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_top      <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_color    <= RESET_COLOR;
            r_strobe   <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_top      <= n_top;
            r_row      <= n_row;
            r_col      <= n_col;
            r_strobe   <= n_strobe;
            if (i_cfg_valid) begin
                r_color <= i_cfg_data;
            end
        end
        r_item     <= n_item;
        r_prow     <= n_prow;
        r_fill_row <= n_fill_row;
        r_fill_col <= n_fill_col;
        r_out_cell <= n_out_cell;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_mem_rdata <= mem[mem_addr];
        end
    end

`ifndef NO_ASSERTIONS
    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> ((r_row < ROW_W'(ROWS - 1)) || (r_row == ROW_W'(ROWS - 1))))
        else $error("cursor row off screen at result");
    a_fill_ends_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL && r_fill_col == COL_W'(COLUMNS - 1))
        |=> (r_strobe && r_col == '0 && r_row == ROW_W'(ROWS - 1)))
        else $error("scroll did not finish at start of last row");
    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_top < ROW_W'(ROWS - 1)) || (r_top == ROW_W'(ROWS - 1)))
        else $error("top row pointer out of range");
`endif

endmodule

// ===== sv/text_console_cursor_scroll_top.sv =====
`timescale 1ns / 1ps
// A put or newline word gives its result strobe once it has passed the queue
// and the executor; a read also waits on the registered store read, and a
// scroll blanks the new bottom row through the single store port first.
// Up to two words queue while the executor works on an earlier one.
// Reset: a clearing pass over all ROWS*COLUMNS cells fills the store with
// grey spaces, busy high throughout. The receiver cannot stall results.
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_top
// Character-cell text console with cursor, line wrap and scroll-up.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_top
    import tcc_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS,
    localparam int ROW_W  = $clog2(ROWS),
    localparam int COL_W  = $clog2(COLUMNS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_operation,
    input  logic [BYTE_W-1:0]   i_character,
    input  logic [ROW_W-1:0]    i_read_row,
    input  logic [COL_W-1:0]    i_read_col,
    output logic                o_strobe,
    output logic [CELL_W-1:0]   o_cell_entry,
    output logic [ROW_W-1:0]    o_cursor_row,
    output logic [COL_W-1:0]    o_cursor_col,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [BYTE_W-1:0]   i_cfg_data
);

    logic   q_push;
    logic   q_pop;
    logic   q_valid;
    logic   q_full;
    logic   clearing;
    t_item  push_item;
    t_item  head_item;

    assign o_cfg_ready = 1'b1;

    tcc_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .start       (start),
        .i_q_full    (q_full),
        .i_clearing  (clearing),
        .i_operation (i_operation),
        .i_character (i_character),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_busy      (busy),
        .o_push      (q_push),
        .o_item      (push_item)
    );

    tcc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_item  (head_item)
    );

    tcc_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_q_valid    (q_valid),
        .i_q_item     (head_item),
        .o_q_pop      (q_pop),
        .o_clearing   (clearing),
        .o_strobe     (o_strobe),
        .o_cell_entry (o_cell_entry),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col)
    );

endmodule
